// ===== rtl/xcbf_pkg.sv =====
package xcbf_pkg;

  localparam logic [7:0]  SOH_BYTE  = 8'h01;
  localparam logic [7:0]  EOT_BYTE  = 8'h04;
  localparam logic [7:0]  PAD_BYTE  = 8'hFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [7:0]  BLOCK_LEN = 8'd128;
  localparam logic [7:0]  HDR_LEN   = 8'd3;
  localparam logic [7:0]  LANES     = 8'd4;

  // one classified payload byte, as handed from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        hdr;      // block header goes out ahead of this byte
    logic [7:0]  blk;      // block number
    logic [7:0]  pos;      // data bytes in block including this one, 1..128
    logic [15:0] crc;      // block crc including this byte
  } entry_t;

  // crc-16 over one byte, msb first, no reflection
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/xcbf_front.sv =====
module xcbf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_byte,
  input  logic                 q_full,
  output logic                 push_valid,
  output xcbf_pkg::entry_t     push_entry
);

  logic [7:0]  blk_r, blk_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  pos_after;
  logic [15:0] crc_after;
  logic        accept;

  assign accept    = in_valid && !q_full;
  assign pos_after = {1'b0, pos_r} + 8'd1;
  assign crc_after = xcbf_pkg::crc_byte(crc_r, in_data_byte);

  assign push_valid      = in_valid;
  assign push_entry.data = in_data_byte;
  assign push_entry.last = in_last_byte;
  assign push_entry.hdr  = (pos_r == 7'd0);
  assign push_entry.blk  = blk_r;
  assign push_entry.pos  = pos_after;
  assign push_entry.crc  = crc_after;

  always_comb begin
    blk_nxt = blk_r;
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    if (accept) begin
      if (in_last_byte) begin
        // transfer ends, next byte starts over at block one
        blk_nxt = 8'd1;
        pos_nxt = 7'd0;
        crc_nxt = 16'h0000;
      end else if (pos_after == xcbf_pkg::BLOCK_LEN) begin
        blk_nxt = blk_r + 8'd1;
        pos_nxt = 7'd0;
        crc_nxt = 16'h0000;
      end else begin
        pos_nxt = pos_after[6:0];
        crc_nxt = crc_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_r <= 8'd1;
      pos_r <= 7'd0;
      crc_r <= 16'h0000;
    end else begin
      blk_r <= blk_nxt;
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
    end
  end

endmodule

// ===== rtl/xcbf_queue.sv =====
module xcbf_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  input  xcbf_pkg::entry_t     push_entry,
  output logic                 full,
  input  logic                 pop,
  output logic                 pop_valid,
  output xcbf_pkg::entry_t     pop_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  xcbf_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          push_ok, pop_ok;

  assign full      = (cnt_r == CW'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_entry = mem_r[rd_ptr_r];
  assign push_ok   = push_valid && !full;
  assign pop_ok    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/xcbf_back.sv =====
module xcbf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  xcbf_pkg::entry_t     q_entry,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_lane_zero,
  output logic [7:0]           out_lane_one,
  output logic [7:0]           out_lane_two,
  output logic [7:0]           out_lane_three,
  output logic [2:0]           out_lane_count,
  output logic                 out_run_end
);

  xcbf_pkg::entry_t cur_r;
  logic        cur_valid_r;
  logic [7:0]  j_r;
  logic [15:0] crc_r;
  logic [6:0]  pad_r;

  logic        out_valid_r;
  logic [7:0]  lane_r [4];
  logic [2:0]  cnt_r;
  logic        end_r;

  logic [7:0]  h3, k, cs, n, rem, j4;
  logic        has_crc, needs_crc, emit, fin, take;
  logic [2:0]  cnt;
  logic [7:0]  idx  [4];
  logic [7:0]  lane [4];
  logic [7:0]  q_pad;

  // pad count of the entry waiting in the queue
  assign q_pad = q_entry.last ? (xcbf_pkg::BLOCK_LEN - q_entry.pos) : 8'd0;

  // layout of the current entry's byte run
  assign h3      = cur_r.hdr ? xcbf_pkg::HDR_LEN : 8'd0;
  assign k       = cur_r.last ? (xcbf_pkg::BLOCK_LEN - cur_r.pos) : 8'd0;
  assign has_crc = cur_r.last || (cur_r.pos == xcbf_pkg::BLOCK_LEN);
  assign cs      = h3 + 8'd1 + k;
  assign n       = cs + (has_crc ? 8'd2 : 8'd0) + (cur_r.last ? 8'd1 : 8'd0);
  assign rem     = n - j_r;
  assign j4      = j_r + xcbf_pkg::LANES;
  assign cnt     = (rem >= xcbf_pkg::LANES) ? 3'd4 : rem[2:0];

  // crc bytes wait until the pad crc has caught up
  assign needs_crc = has_crc && (cs < j4);
  assign emit = cur_valid_r && !(needs_crc && (pad_r != 7'd0)) &&
                (!out_valid_r || !out_stall);
  assign fin  = emit && (rem <= xcbf_pkg::LANES);
  assign take = q_valid && (!cur_valid_r || fin);
  assign q_pop = take;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      idx[l] = j_r + 8'(l);
      if (l >= int'(cnt)) begin
        lane[l] = 8'h00;
      end else if (cur_r.hdr && idx[l] == 8'd0) begin
        lane[l] = xcbf_pkg::SOH_BYTE;
      end else if (cur_r.hdr && idx[l] == 8'd1) begin
        lane[l] = cur_r.blk;
      end else if (cur_r.hdr && idx[l] == 8'd2) begin
        lane[l] = ~cur_r.blk;
      end else if (idx[l] == h3) begin
        lane[l] = cur_r.data;
      end else if (idx[l] < cs) begin
        lane[l] = xcbf_pkg::PAD_BYTE;
      end else if (idx[l] == cs) begin
        lane[l] = crc_r[15:8];
      end else if (idx[l] == cs + 8'd1) begin
        lane[l] = crc_r[7:0];
      end else begin
        lane[l] = xcbf_pkg::EOT_BYTE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_r <= q_entry;
      j_r   <= 8'd0;
      crc_r <= q_entry.crc;
      pad_r <= q_pad[6:0];
    end else begin
      if (emit) begin
        j_r <= j4;
      end
      if (cur_valid_r && pad_r != 7'd0) begin
        crc_r <= xcbf_pkg::crc_byte(crc_r, xcbf_pkg::PAD_BYTE);
        pad_r <= pad_r - 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      for (int l = 0; l < 4; l++) begin
        lane_r[l] <= lane[l];
      end
      cnt_r <= cnt;
      end_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        cur_valid_r <= 1'b1;
      end else if (fin) begin
        cur_valid_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_lane_zero  = lane_r[0];
  assign out_lane_one   = lane_r[1];
  assign out_lane_two   = lane_r[2];
  assign out_lane_three = lane_r[3];
  assign out_lane_count = cnt_r;
  assign out_run_end    = end_r;

endmodule

// ===== rtl/xmodem_crc_block_framer.sv =====
// xmodem-crc block framer
// input channel: one payload byte per beat (in_data_byte), in_last_byte marks
//   the end of the transfer; in_stall is high while the internal queue is full
// output channel: frame bytes packed four to a beat, out_lane_count says how
//   many lanes from lane zero hold bytes, out_run_end flags the last beat
//   caused by one input byte
// frames: soh, block number, its complement, 128 data bytes, crc-16 high/low;
//   on the last byte a partial block is padded with 0xff, closed, then eot
// path: an input byte passes the queue, then the back end's entry register and the output register
// throughput: one input byte per cycle outside the last byte while neither
//   stall is raised; each of those gives exactly one output beat
// last byte: the pad crc is folded one pad byte per cycle, and the beat with
//   its crc bytes waits until every pad byte has been folded in
// reset: block number back to 1, queue and output stage emptied
// receiver stall: the output register holds its beat, the back end stops
//   emitting, the queue takes up to QUEUE_DEPTH more input beats before in_stall
module xmodem_crc_block_framer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_lane_zero,
  output logic [7:0] out_lane_one,
  output logic [7:0] out_lane_two,
  output logic [7:0] out_lane_three,
  output logic [2:0] out_lane_count,
  output logic       out_run_end
);

  // front to queue
  logic             push_valid;
  xcbf_pkg::entry_t push_entry;
  logic             q_full;

  // queue to back
  logic             q_valid;
  logic             q_pop;
  xcbf_pkg::entry_t q_entry;

  assign in_stall = q_full;

  // front: block numbering, header decision, running crc per data byte
  xcbf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .push_valid   (push_valid),
    .push_entry   (push_entry)
  );

  // short decoupling queue
  xcbf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry)
  );

  // back: byte sequencing, padding crc, lane packing, output register
  xcbf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_lane_zero  (out_lane_zero),
    .out_lane_one   (out_lane_one),
    .out_lane_two   (out_lane_two),
    .out_lane_three (out_lane_three),
    .out_lane_count (out_lane_count),
    .out_run_end    (out_run_end)
  );

endmodule
